@@ rtl/pcdf_pkg.sv @@
// Shared types and constants for the point change deadband filter.
// Used by pcdf_eval, the top level and the testbench; no dependencies of its own.
package pcdf_pkg;

   // Per-point table size and its address width
   localparam int POINT_COUNT = 4096;
   localparam int PT_AW       = $clog2(POINT_COUNT);

   // Field widths
   localparam int POINT_W = 12;
   localparam int QUAL_W  = 8;
   localparam int VAL_W   = 32;
   localparam int TIME_W  = 32;
   localparam int HIST_W  = VAL_W + TIME_W;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   // Deadband product width: 32-bit magnitude times up to a 10-bit factor
   localparam int PROD_W     = 42;
   localparam int DIFF_SCALE = 1000;

   // Quality constants
   localparam logic [QUAL_W-1:0] QUAL_CLEAR    = 8'hFF;
   localparam logic [QUAL_W-1:0] DIG_QUAL_MASK = 8'hF7 & 8'hFD;

   // Update kinds
   typedef enum logic [1:0] {
      FUNC_DIGITAL = 2'd0,
      FUNC_ANALOG  = 2'd1,
      FUNC_EVENT   = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   // Register indexes (word address)
   localparam logic [2:0] REG_FAST_WIN = 3'd0;
   localparam logic [2:0] REG_SLOW_WIN = 3'd1;
   localparam logic [2:0] REG_FAST_ABS = 3'd2;
   localparam logic [2:0] REG_SLOW_ABS = 3'd3;
   localparam logic [2:0] REG_FAST_REL = 3'd4;
   localparam logic [2:0] REG_SLOW_REL = 3'd5;
   localparam logic [2:0] REG_CUTOFF   = 3'd6;

   // Deadband configuration
   typedef struct packed {
      logic [15:0] fast_window;
      logic [15:0] slow_window;
      logic [15:0] fast_abs;
      logic [15:0] slow_abs;
      logic [9:0]  fast_rel;
      logic [9:0]  slow_rel;
      logic [30:0] cutoff;
   } cfg_type;

   // Operands of one analog evaluation
   typedef struct packed {
      logic [VAL_W-1:0]  sample;
      logic [VAL_W-1:0]  prev_value;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] prev_time;
   } eval_in_type;

endpackage

@@ rtl/pcdf_ram.sv @@
// Single-port synchronous RAM with a registered read port.
// Generic; used for the per-point quality and history tables.
module pcdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, or read into the registered output
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/pcdf_eval.sv @@
// Two-stage analog deadband evaluation: differences, then products and compares.
// Depends on pcdf_pkg for the configuration and operand types.
module pcdf_eval (
   input  logic                  clock,
   input  pcdf_pkg::cfg_type     cfg,
   input  pcdf_pkg::eval_in_type item,
   output logic                  step_hit
);

   logic [32:0]                     diff_wide;
   logic [31:0]                     diff_mag;
   logic [31:0]                     sample_mag;
   logic [pcdf_pkg::TIME_W-1:0]     elapsed;

   logic [31:0]                     diff_ff;
   logic [31:0]                     mag_ff;
   logic [pcdf_pkg::TIME_W-1:0]     elapsed_ff;

   logic [pcdf_pkg::PROD_W-1:0]     prod_diff_ff;
   logic [pcdf_pkg::PROD_W-1:0]     prod_fast_ff;
   logic [pcdf_pkg::PROD_W-1:0]     prod_slow_ff;
   logic                            big_ff;
   logic                            abs_fast_ff;
   logic                            abs_slow_ff;
   logic                            win_fast_ff;
   logic                            win_slow_ff;

   // Form magnitudes and elapsed time
   always_comb begin
      diff_wide  = {item.sample[31], item.sample} - {item.prev_value[31], item.prev_value};
      diff_mag   = diff_wide[32] ? 32'(~diff_wide + 33'd1) : diff_wide[31:0];
      sample_mag = item.sample[31] ? (~item.sample + 32'd1) : item.sample;
      elapsed    = item.now - item.prev_time;
   end

   // Stage one: hold magnitudes
   always_ff @(posedge clock) begin
      diff_ff    <= diff_mag;
      mag_ff     <= sample_mag;
      elapsed_ff <= elapsed;
   end

   // Stage two: scale both sides of the relative test, compare the rest
   always_ff @(posedge clock) begin
      prod_diff_ff <= pcdf_pkg::PROD_W'(diff_ff) * pcdf_pkg::PROD_W'(pcdf_pkg::DIFF_SCALE);
      prod_fast_ff <= pcdf_pkg::PROD_W'(mag_ff) * pcdf_pkg::PROD_W'(cfg.fast_rel);
      prod_slow_ff <= pcdf_pkg::PROD_W'(mag_ff) * pcdf_pkg::PROD_W'(cfg.slow_rel);
      big_ff       <= mag_ff > {1'b0, cfg.cutoff};
      abs_fast_ff  <= diff_ff >= 32'(cfg.fast_abs);
      abs_slow_ff  <= diff_ff >= 32'(cfg.slow_abs);
      win_fast_ff  <= elapsed_ff >= 32'(cfg.fast_window);
      win_slow_ff  <= elapsed_ff >= 32'(cfg.slow_window);
   end

   // Either window with its step met
   always_comb begin
      step_hit = (win_fast_ff && (big_ff ? (prod_diff_ff > prod_fast_ff) : abs_fast_ff)) ||
                 (win_slow_ff && (big_ff ? (prod_diff_ff > prod_slow_ff) : abs_slow_ff));
   end

endmodule

@@ rtl/point_change_deadband_filter.sv @@
// Point change deadband filter: top level with the sequencer and the tables.
// Depends on pcdf_pkg, pcdf_ram and pcdf_eval.
//
// Usage: each req beat is one point update (tuser = kind: digital list,
// analog list or digital event). Each accepted beat yields exactly one rsp
// beat telling whether the update goes to history, with the echoed point,
// digital state bit and output quality byte.
// Per-point state lives in two single-port RAMs: a quality table and a
// value/time history table. One item goes through accept, table read,
// two evaluation steps and a write-back/result step, one item at a time
// as set by the read-modify-write sequence on the table port.
// A list item carrying the new-day flag first sweeps the quality table to
// 255, one entry a cycle, over all POINT_COUNT (4096) entries.
// Reset: a clearing pass over all POINT_COUNT (4096) entries sets qualities to 255
// and values and times to zero; req_tready stays low meanwhile. The csr
// port takes writes at any time, with pready always high.
// Stall: the result waits in the rsp output register; the next item is
// accepted and worked on, and holds in its last cycle until the slot frees.
module point_change_deadband_filter (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, from bit 0: point[11:0], quality[19:12], sample[51:20],
   // now_seconds[83:52], new_day[84], zero fill[87:85]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pcdf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser, from bit 0: func[1:0]
   input  logic [1:0]                         req_tuser,
   // rsp_tdata, from bit 0: record[0], point_out[12:1], state_bit[13],
   // quality_out[21:14], zero fill[23:22]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pcdf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcdf_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [pcdf_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [pcdf_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SWEEP = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_EVAL1 = 7'b0010000,
      ST_EVAL2 = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [pcdf_pkg::PT_AW-1:0]       sweep_idx_ff, sweep_idx_in;
   logic                             sweep_last;

   pcdf_pkg::func_type               func_ff;
   logic [pcdf_pkg::POINT_W-1:0]     point_ff;
   logic [pcdf_pkg::QUAL_W-1:0]      quality_ff;
   logic [pcdf_pkg::VAL_W-1:0]       sample_ff;
   logic [pcdf_pkg::TIME_W-1:0]      now_ff;

   pcdf_pkg::cfg_type                cfg_ff;
   logic                             csr_write;

   logic                             req_accept;
   logic                             req_new_day;
   pcdf_pkg::func_type               req_func;
   logic                             in_table;

   logic [pcdf_pkg::PT_AW-1:0]       tbl_addr;
   logic                             tbl_re;
   logic                             qual_we;
   logic [pcdf_pkg::QUAL_W-1:0]      qual_wdata;
   logic [pcdf_pkg::QUAL_W-1:0]      qual_rdata;
   logic                             hist_we;
   logic [pcdf_pkg::HIST_W-1:0]      hist_wdata;
   logic [pcdf_pkg::HIST_W-1:0]      hist_rdata;

   pcdf_pkg::eval_in_type            eval_item;
   logic                             step_hit;

   logic                             rec;
   logic                             sbit;
   logic [pcdf_pkg::QUAL_W-1:0]      qout;
   logic                             qual_upd;
   logic                             hist_upd;
   logic                             rsp_fire;

   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [pcdf_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;

   // Input handshake
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign req_func    = pcdf_pkg::func_type'(req_tuser);
   assign req_new_day = req_tdata[84];

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_window <= 16'd60;
         cfg_ff.slow_window <= 16'd300;
         cfg_ff.fast_abs    <= 16'd50;
         cfg_ff.slow_abs    <= 16'd20;
         cfg_ff.fast_rel    <= 10'd5;
         cfg_ff.slow_rel    <= 10'd2;
         cfg_ff.cutoff      <= 31'd10000;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            pcdf_pkg::REG_FAST_WIN: cfg_ff.fast_window <= csr_pwdata[15:0];
            pcdf_pkg::REG_SLOW_WIN: cfg_ff.slow_window <= csr_pwdata[15:0];
            pcdf_pkg::REG_FAST_ABS: cfg_ff.fast_abs    <= csr_pwdata[15:0];
            pcdf_pkg::REG_SLOW_ABS: cfg_ff.slow_abs    <= csr_pwdata[15:0];
            pcdf_pkg::REG_FAST_REL: cfg_ff.fast_rel    <= csr_pwdata[9:0];
            pcdf_pkg::REG_SLOW_REL: cfg_ff.slow_rel    <= csr_pwdata[9:0];
            pcdf_pkg::REG_CUTOFF:   cfg_ff.cutoff      <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (csr_paddr[4:2])
         pcdf_pkg::REG_FAST_WIN: csr_prdata = 32'(cfg_ff.fast_window);
         pcdf_pkg::REG_SLOW_WIN: csr_prdata = 32'(cfg_ff.slow_window);
         pcdf_pkg::REG_FAST_ABS: csr_prdata = 32'(cfg_ff.fast_abs);
         pcdf_pkg::REG_SLOW_ABS: csr_prdata = 32'(cfg_ff.slow_abs);
         pcdf_pkg::REG_FAST_REL: csr_prdata = 32'(cfg_ff.fast_rel);
         pcdf_pkg::REG_SLOW_REL: csr_prdata = 32'(cfg_ff.slow_rel);
         pcdf_pkg::REG_CUTOFF:   csr_prdata = 32'(cfg_ff.cutoff);
         default:                csr_prdata = '0;
      endcase
   end

   // Capture the item on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff    <= req_func;
         point_ff   <= req_tdata[11:0];
         quality_ff <= req_tdata[19:12];
         sample_ff  <= req_tdata[51:20];
         now_ff     <= req_tdata[83:52];
      end
   end

   assign in_table   = 32'(point_ff) < 32'(pcdf_pkg::POINT_COUNT);
   assign sweep_last = (sweep_idx_ff == pcdf_pkg::PT_AW'(pcdf_pkg::POINT_COUNT - 1));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_idx_in = sweep_idx_ff;
      case (state_ff)
         ST_INIT: begin
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_last) begin
               sweep_idx_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_new_day &&
                   (req_func == pcdf_pkg::FUNC_DIGITAL || req_func == pcdf_pkg::FUNC_ANALOG)) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SWEEP: begin
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_last) begin
               sweep_idx_in = '0;
               state_in     = ST_READ;
            end
         end
         ST_READ:  state_in = ST_EVAL1;
         ST_EVAL1: state_in = ST_EVAL2;
         ST_EVAL2: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
      end
   end

   // Decide record and result fields from the table read
   always_comb begin
      rec      = 1'b0;
      sbit     = 1'b0;
      qout     = '0;
      qual_upd = 1'b0;
      hist_upd = 1'b0;
      case (func_ff)
         pcdf_pkg::FUNC_DIGITAL: begin
            sbit     = quality_ff[0];
            qout     = quality_ff & pcdf_pkg::DIG_QUAL_MASK;
            rec      = in_table && (qual_rdata != quality_ff);
            qual_upd = rec;
         end
         pcdf_pkg::FUNC_EVENT: begin
            sbit = quality_ff[0];
            qout = quality_ff & pcdf_pkg::DIG_QUAL_MASK;
            rec  = in_table && (qual_rdata != pcdf_pkg::QUAL_CLEAR);
         end
         pcdf_pkg::FUNC_ANALOG: begin
            qout     = quality_ff;
            rec      = in_table && ((qual_rdata != quality_ff) || step_hit);
            qual_upd = rec;
            hist_upd = rec;
         end
         default: ;
      endcase
   end

   assign rsp_fire = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // Table port control: sweep, read, or write back
   always_comb begin
      tbl_re     = (state_ff == ST_READ);
      tbl_addr   = pcdf_pkg::PT_AW'(point_ff);
      qual_we    = rsp_fire && qual_upd;
      qual_wdata = quality_ff;
      hist_we    = rsp_fire && hist_upd;
      hist_wdata = {sample_ff, now_ff};
      if (state_ff == ST_INIT || state_ff == ST_SWEEP) begin
         tbl_addr   = sweep_idx_ff;
         qual_we    = 1'b1;
         qual_wdata = pcdf_pkg::QUAL_CLEAR;
      end
      if (state_ff == ST_INIT) begin
         hist_we    = 1'b1;
         hist_wdata = '0;
      end
   end

   pcdf_ram #(
      .WIDTH (pcdf_pkg::QUAL_W),
      .DEPTH (pcdf_pkg::POINT_COUNT)
   ) u_qual_ram (
      .clock (clock),
      .addr  (tbl_addr),
      .we    (qual_we),
      .wdata (qual_wdata),
      .re    (tbl_re),
      .rdata (qual_rdata)
   );

   pcdf_ram #(
      .WIDTH (pcdf_pkg::HIST_W),
      .DEPTH (pcdf_pkg::POINT_COUNT)
   ) u_hist_ram (
      .clock (clock),
      .addr  (tbl_addr),
      .we    (hist_we),
      .wdata (hist_wdata),
      .re    (tbl_re),
      .rdata (hist_rdata)
   );

   // Analog deadband evaluation
   always_comb begin
      eval_item.sample     = sample_ff;
      eval_item.prev_value = hist_rdata[pcdf_pkg::HIST_W-1:pcdf_pkg::TIME_W];
      eval_item.now        = now_ff;
      eval_item.prev_time  = hist_rdata[pcdf_pkg::TIME_W-1:0];
   end

   pcdf_eval u_eval (
      .clock    (clock),
      .cfg      (cfg_ff),
      .item     (eval_item),
      .step_hit (step_hit)
   );

   // Result register: load on fire, drop on take
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_fire) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_tdata_ff <= {2'b00, qout, sbit, point_ff, rec};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
   a_sweep_after_new_day: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_new_day &&
       (req_func == pcdf_pkg::FUNC_DIGITAL || req_func == pcdf_pkg::FUNC_ANALOG))
      |=> (state_ff == ST_SWEEP))
      else $error("new-day list item did not start a quality sweep");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result loaded over a pending beat");

   a_hist_write_needs_record: assert property (@(posedge clock) disable iff (reset)
      (hist_we && state_ff != ST_INIT) |-> (rec && func_ff == pcdf_pkg::FUNC_ANALOG))
      else $error("history written without an analog record");

   a_no_read_during_write: assert property (@(posedge clock) disable iff (reset)
      tbl_re |-> (!qual_we && !hist_we))
      else $error("table read collides with a write");

endmodule

@@ tb/sv/tb_point_change_deadband_filter.sv @@
// Self-checking testbench for point_change_deadband_filter: drives point updates
// on the req stream, csr writes on the APB port, checks every rsp beat.
// Depends on pcdf_pkg and the RTL of the block only.
module tb_point_change_deadband_filter;

   timeunit 1ns;
   timeprecision 1ps;

   // Register index that decodes to nothing
   localparam logic [2:0] REG_NONE = 3'd7;

   typedef struct packed {
      pcdf_pkg::func_type func;
      logic [11:0]        point;
      logic [7:0]         quality;
      logic [31:0]        sample;
      logic [31:0]        now;
      logic               new_day;
   } point_update_type;

   // Same bit order as rsp_tdata[21:0]
   typedef struct packed {
      logic [7:0]  quality;
      logic        state_bit;
      logic [11:0] point;
      logic        record;
   } decision_type;

   // Predicts the history decision of every accepted update
   class record_predictor_type;
      pcdf_pkg::cfg_type cfg;
      logic [7:0]        last_quality [pcdf_pkg::POINT_COUNT];
      logic [31:0]       last_value [pcdf_pkg::POINT_COUNT];
      logic [31:0]       last_time [pcdf_pkg::POINT_COUNT];
      decision_type      pending_records[$];
      int                errors;

      function new();
         cfg.fast_window = 16'd60;
         cfg.slow_window = 16'd300;
         cfg.fast_abs    = 16'd50;
         cfg.slow_abs    = 16'd20;
         cfg.fast_rel    = 10'd5;
         cfg.slow_rel    = 10'd2;
         cfg.cutoff      = 31'd10000;
         foreach (last_quality[i]) begin
            last_quality[i] = pcdf_pkg::QUAL_CLEAR;
            last_value[i]   = '0;
            last_time[i]    = '0;
         end
         errors = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            pcdf_pkg::REG_FAST_WIN: cfg.fast_window = value[15:0];
            pcdf_pkg::REG_SLOW_WIN: cfg.slow_window = value[15:0];
            pcdf_pkg::REG_FAST_ABS: cfg.fast_abs    = value[15:0];
            pcdf_pkg::REG_SLOW_ABS: cfg.slow_abs    = value[15:0];
            pcdf_pkg::REG_FAST_REL: cfg.fast_rel    = value[9:0];
            pcdf_pkg::REG_SLOW_REL: cfg.slow_rel    = value[9:0];
            pcdf_pkg::REG_CUTOFF:   cfg.cutoff      = value[30:0];
            default: ;
         endcase
      endfunction

      // Relative step above the cutoff, absolute step at or below it
      function bit step_met(longint unsigned mag, longint unsigned diff,
                            logic [9:0] rel, logic [15:0] step);
         if (mag > 64'(cfg.cutoff))
            return diff * 64'd1000 > mag * 64'(rel);
         return diff >= 64'(step);
      endfunction

      function void note_update(point_update_type u);
         decision_type    d;
         longint          x;
         longint          dv;
         longint unsigned mag;
         longint unsigned diff;
         logic [31:0]     elapsed;
         bit              hit;
         bit              in_table;
         d = '0;
         d.point = u.point;
         in_table = int'(u.point) < pcdf_pkg::POINT_COUNT;
         // new day wipes all qualities, but only for list items
         if ((u.func == pcdf_pkg::FUNC_DIGITAL || u.func == pcdf_pkg::FUNC_ANALOG) &&
             u.new_day)
            foreach (last_quality[i]) last_quality[i] = pcdf_pkg::QUAL_CLEAR;
         case (u.func)
            pcdf_pkg::FUNC_DIGITAL, pcdf_pkg::FUNC_EVENT: begin
               d.state_bit = u.quality[0];
               d.quality = u.quality & pcdf_pkg::DIG_QUAL_MASK;
               if (in_table) begin
                  if (u.func == pcdf_pkg::FUNC_DIGITAL) begin
                     if (last_quality[u.point] != u.quality) begin
                        d.record = 1'b1;
                        last_quality[u.point] = u.quality;
                     end
                  end else if (last_quality[u.point] != pcdf_pkg::QUAL_CLEAR) begin
                     d.record = 1'b1;
                  end
               end
            end
            pcdf_pkg::FUNC_ANALOG: begin
               d.quality = u.quality;
               if (in_table) begin
                  x = longint'($signed(u.sample));
                  dv = x - longint'($signed(last_value[u.point]));
                  mag = (x < 0) ? -x : x;
                  diff = (dv < 0) ? -dv : dv;
                  elapsed = u.now - last_time[u.point];
                  hit = last_quality[u.point] != u.quality;
                  if (!hit && elapsed >= 32'(cfg.fast_window) &&
                      step_met(mag, diff, cfg.fast_rel, cfg.fast_abs))
                     hit = 1'b1;
                  if (!hit && elapsed >= 32'(cfg.slow_window) &&
                      step_met(mag, diff, cfg.slow_rel, cfg.slow_abs))
                     hit = 1'b1;
                  if (hit) begin
                     d.record = 1'b1;
                     last_quality[u.point] = u.quality;
                     last_value[u.point]   = u.sample;
                     last_time[u.point]    = u.now;
                  end
               end
            end
            default: ;
         endcase
         pending_records.push_back(d);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_decision(decision_type got);
         decision_type want;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected result beat, got 0x%0h", $time, got);
            errors++;
            return;
         end
         want = pending_records.pop_front();
         compare_field("record", 32'(want.record), 32'(got.record));
         compare_field("point_out", 32'(want.point), 32'(got.point));
         compare_field("state_bit", 32'(want.state_bit), 32'(got.state_bit));
         compare_field("quality_out", 32'(want.quality), 32'(got.quality));
      endfunction

      function int pending();
         return pending_records.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pcdf_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]                       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pcdf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [pcdf_pkg::CSR_AW-1:0]      csr_paddr = '0;
   logic [pcdf_pkg::CSR_DW-1:0]      csr_pwdata = '0;
   logic [pcdf_pkg::CSR_DW-1:0]      csr_prdata;
   logic                             csr_pready;

   record_predictor_type board = new();
   int                      burst_left = 0;
   int                      day_clears = 0;
   logic [31:0]             wall_seconds = '0;
   logic [11:0]             hot_points [16];
   logic [7:0]              hot_qualities [4] = '{8'h00, 8'h01, 8'hC0, 8'hC1};

   point_change_deadband_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Setup phase, then access phase until pready, then idle with psel low
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] fw, input logic [31:0] sw,
                            input logic [31:0] fa, input logic [31:0] sa,
                            input logic [31:0] fr, input logic [31:0] sr,
                            input logic [31:0] cut);
      csr_write(pcdf_pkg::REG_FAST_WIN, fw);
      csr_write(pcdf_pkg::REG_SLOW_WIN, sw);
      csr_write(pcdf_pkg::REG_FAST_ABS, fa);
      csr_write(pcdf_pkg::REG_SLOW_ABS, sa);
      csr_write(pcdf_pkg::REG_FAST_REL, fr);
      csr_write(pcdf_pkg::REG_SLOW_REL, sr);
      csr_write(pcdf_pkg::REG_CUTOFF, cut);
   endtask

   // Offer one beat, with a random gap whenever a burst runs out
   task automatic send_update(input point_update_type u);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, u.new_day, u.now, u.sample, u.quality, u.point};
      req_tuser  <= u.func;
      do @(posedge clock); while (!req_tready);
      board.note_update(u);
   endtask

   task automatic send_fields(input pcdf_pkg::func_type f, input logic [11:0] p,
                              input logic [7:0] q, input logic [31:0] s,
                              input logic [31:0] t, input logic nd);
      point_update_type u;
      u.func = f;
      u.point = p;
      u.quality = q;
      u.sample = s;
      u.now = t;
      u.new_day = nd;
      send_update(u);
   endtask

   // Lower valid and let every expected result come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic pick_hot_points();
      hot_points[0] = 12'd0;
      hot_points[1] = 12'd4095;
      for (int i = 2; i < 16; i++) hot_points[i] = 12'($urandom);
   endtask

   // Mostly repeated updates to a few points, with samples near the deadband
   function automatic point_update_type random_update();
      point_update_type u;
      int               pick;
      longint           b;
      longint           span;
      pick = $urandom_range(0, 99);
      u.func = (pick < 38) ? pcdf_pkg::FUNC_ANALOG :
               (pick < 70) ? pcdf_pkg::FUNC_DIGITAL :
               (pick < 96) ? pcdf_pkg::FUNC_EVENT : pcdf_pkg::FUNC_UNUSED;
      u.point = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                            : hot_points[$urandom_range(0, 15)];
      case ($urandom_range(0, 5))
         0: u.quality = pcdf_pkg::QUAL_CLEAR;
         1, 2: u.quality = hot_qualities[$urandom_range(0, 3)];
         3, 4: u.quality = board.last_quality[u.point];
         default: u.quality = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: ;
         1, 2, 3, 4, 5: wall_seconds += 32'($urandom_range(0, 30));
         6, 7, 8: wall_seconds += 32'($urandom_range(30, 400));
         default: wall_seconds += 32'($urandom_range(400, 70000));
      endcase
      u.now = wall_seconds;
      b = longint'($signed(board.last_value[u.point]));
      case ($urandom_range(0, 7))
         0: u.sample = $urandom;
         1: u.sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2, 3: u.sample = 32'(b + longint'($urandom_range(0, 120)) - 60);
         4, 5: begin
            span = ((b < 0) ? -b : b) / 100 + 1;
            u.sample = 32'(b + longint'($urandom_range(0, 32'(2 * span))) - span);
         end
         default: u.sample = 32'($urandom_range(0, 30000)) - 32'd15000;
      endcase
      u.new_day = 1'b0;
      if (u.func != pcdf_pkg::FUNC_ANALOG && u.func != pcdf_pkg::FUNC_DIGITAL)
         u.new_day = 1'($urandom);
      else if (day_clears < 20 && $urandom_range(0, 79) == 0) begin
         u.new_day = 1'b1;
         day_clears++;
      end
      return u;
   endfunction

   task automatic run_random(input int count);
      pick_hot_points();
      repeat (count) send_update(random_update());
      drain_results();
   endtask

   // Receiver: changing stall patterns plus one long hold-off
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      int  delivered;
      bit  held_long;
      bit  ready;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      delivered = 0;
      held_long = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_decision(decision_type'(rsp_tdata[21:0]));
            delivered++;
         end
         if (!held_long && delivered >= 200) begin
            held_long = 1'b1;
            hold_left = 300;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            0: ready = 1'b1;
            1: ready = 1'($urandom);
            default: ready = ($urandom_range(0, 3) == 0);
         endcase
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end
         rsp_tready <= ready;
      end
   end

   initial begin
      #4_000_000;
      $display("tb_point_change_deadband_filter failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part on reset settings
      send_fields(pcdf_pkg::FUNC_DIGITAL, 12'd0, 8'h00, 32'd0, 32'd0, 1'b0);
      send_fields(pcdf_pkg::FUNC_DIGITAL, 12'd0, 8'h00, 32'd0, 32'd0, 1'b0);
      send_fields(pcdf_pkg::FUNC_DIGITAL, 12'd4095, 8'hFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
      send_fields(pcdf_pkg::FUNC_EVENT, 12'd0, 8'hFF, 32'd0, 32'd1, 1'b0);
      send_fields(pcdf_pkg::FUNC_EVENT, 12'd4095, 8'h0A, 32'd0, 32'd1, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd1, 8'hC0, 32'd0, 32'd0, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd1, 8'hC0, 32'd49, 32'd59, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd1, 8'hC0, 32'd50, 32'd60, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd1, 8'hC0, 32'd69, 32'd360, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd1, 8'hC0, 32'd70, 32'd660, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd2, 8'h00, 32'h7FFF_FFFF, 32'd700, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd2, 8'h00, 32'h8000_0000, 32'd800, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd3, 8'h01, 32'd20000, 32'd800, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd3, 8'h01, 32'd20100, 32'd860, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd3, 8'h01, 32'd20102, 32'd860, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd3, 8'h01, -32'd20202, 32'd1200, 1'b0);
      send_fields(pcdf_pkg::FUNC_UNUSED, 12'd5, 8'hAB, 32'd7, 32'd1200, 1'b0);
      send_fields(pcdf_pkg::FUNC_UNUSED, 12'd5, 8'hFF, 32'd7, 32'd1200, 1'b1);
      send_fields(pcdf_pkg::FUNC_EVENT, 12'd0, 8'h01, 32'd0, 32'd1200, 1'b1);
      send_fields(pcdf_pkg::FUNC_EVENT, 12'd0, 8'hFE, 32'd0, 32'd1201, 1'b0);
      send_fields(pcdf_pkg::FUNC_DIGITAL, 12'd0, 8'h00, 32'd0, 32'd1202, 1'b1);
      send_fields(pcdf_pkg::FUNC_EVENT, 12'd1, 8'h00, 32'd0, 32'd1202, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd9, 8'hFF, 32'd10, 32'd1300, 1'b0);
      send_fields(pcdf_pkg::FUNC_ANALOG, 12'd1, 8'hC0, 32'd70, 32'd1300, 1'b1);
      drain_results();

      // Every register at its top, plus a write that decodes to nothing
      write_all('1, '1, '1, '1, '1, '1, '1);
      csr_write(REG_NONE, 32'd1);
      wall_seconds = 32'd2000;
      run_random(200);

      // Every register at zero
      write_all('0, '0, '0, '0, '0, '0, '0);
      run_random(200);

      // Back to the usual settings, with time wrapping past 2^32
      write_all(32'd60, 32'd300, 32'd50, 32'd20, 32'd5, 32'd2, 32'd10000);
      wall_seconds = 32'hFFFF_F000;
      run_random(350);

      // Random settings
      repeat (2) begin
         write_all($urandom_range(0, 400), $urandom_range(0, 400),
                   $urandom_range(0, 200), $urandom_range(0, 200),
                   $urandom_range(0, 1000), $urandom_range(0, 1000),
                   $urandom_range(0, 1) ? $urandom_range(0, 30000) : $urandom);
         run_random(300);
      end

      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_point_change_deadband_filter passed");
      end else begin
         $display("tb_point_change_deadband_filter failed");
      end
      $finish;
   end

endmodule
